// ===== design/ssp_pkg.sv =====
// ----------------------------------------------------------------------------
// Shortest-path engine package
// Sizes, word types, controller states, datapath commands and status.
// ----------------------------------------------------------------------------
package ssp_pkg;

   localparam int MAX_VERTICES = 2048;
   localparam int MAX_EDGES    = 4096;
   localparam int WEIGHT_BITS  = 16;
   localparam int DIR_SLOTS    = 2 * MAX_EDGES;
   localparam int HEAP_SLOTS   = DIR_SLOTS + 1;
   localparam int DIST_BITS    = 27;

   localparam int VTX_W  = $clog2(MAX_VERTICES);
   localparam int EADR_W = $clog2(DIR_SLOTS);
   localparam int LINK_W = $clog2(DIR_SLOTS + 1);
   localparam int HADR_W = $clog2(HEAP_SLOTS);
   localparam int CNT_W  = $clog2(HEAP_SLOTS + 1);

   localparam logic [1:0] FUNC_ADD   = 2'd0;
   localparam logic [1:0] FUNC_RUN   = 2'd1;
   localparam logic [1:0] FUNC_QUERY = 2'd2;
   localparam logic [1:0] FUNC_CLEAR = 2'd3;

   typedef struct packed {
      logic [1:0]  func;
      logic [10:0] vertex_a;
      logic [10:0] vertex_b;
      logic [15:0] edge_weight;
   } req_type;

   typedef struct packed {
      logic [26:0] distance;
      logic        reachable;
      logic        status;
   } rsp_type;

   typedef struct packed {
      logic [VTX_W-1:0]       dest;
      logic [WEIGHT_BITS-1:0] weight;
      logic [LINK_W-1:0]      next;
   } edge_type;

   typedef struct packed {
      logic [DIST_BITS-1:0] len;
      logic                 reached;
   } dist_type;

   typedef struct packed {
      logic [DIST_BITS-1:0] key;
      logic [VTX_W-1:0]     vtx;
   } heap_type;

   typedef enum logic [4:0] {
      S_INIT, S_IDLE, S_ADD_CHK, S_ADD_W1, S_ADD_RD_B, S_ADD_W2,
      S_Q_RD, S_Q_DATA, S_CLR, S_RUN_CLR, S_RUN_SRC, S_LOOP,
      S_POP_RDL, S_POP_LAST, S_SIFT_RL, S_SIFT_RR, S_SIFT_STEP, S_SIFT_PLACE,
      S_CHK_RD, S_CHK, S_LINK, S_EDGE, S_EDGE_D, S_RELAX, S_UP_CHK, S_UP_STEP,
      S_DONE
   } state_type;

   typedef enum logic [4:0] {
      CMD_NONE, CMD_ACCEPT, CMD_HEAD_SWEEP, CMD_ADD_RD_A, CMD_ADD_WR_A,
      CMD_ADD_RD_B, CMD_ADD_WR_B, CMD_Q_RD, CMD_Q_DATA, CMD_DIST_SWEEP,
      CMD_RUN_SRC, CMD_POP_RD0, CMD_POP_RDL, CMD_POP_LAST, CMD_SIFT_RDL,
      CMD_SIFT_RDR, CMD_SIFT_STEP, CMD_SIFT_PLACE, CMD_CHK_RD, CMD_CHK,
      CMD_LINK, CMD_EDGE_RD, CMD_EDGE_DATA, CMD_RELAX, CMD_UP_CHK,
      CMD_UP_STEP, CMD_OUT
   } cmd_type;

   typedef struct packed {
      logic full;
      logic sweep_last;
      logic size_zero;
      logic l_in;
      logic sift_move;
      logic stale;
      logic link_zero;
      logic relax_ok;
      logic heap_full;
      logic i_zero;
      logic up_stop;
      logic out_free;
   } status_type;

endpackage

// ===== design/ssp_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ssp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/ssp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Shortest-path engine controller
// Sequences edge loads, queries, clears and the heap-driven search.
// ----------------------------------------------------------------------------
module ssp_ctrl import ssp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_func,
   input  status_type status,
   output logic       req_stall,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_INIT:       if (status.sweep_last) state_in = S_IDLE;
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_func)
                  FUNC_ADD:   state_in = S_ADD_CHK;
                  FUNC_RUN:   state_in = S_RUN_CLR;
                  FUNC_QUERY: state_in = S_Q_RD;
                  default:    state_in = S_CLR;
               endcase
            end
         end
         S_ADD_CHK:    state_in = status.full ? S_DONE : S_ADD_W1;
         S_ADD_W1:     state_in = S_ADD_RD_B;
         S_ADD_RD_B:   state_in = S_ADD_W2;
         S_ADD_W2:     state_in = S_DONE;
         S_Q_RD:       state_in = S_Q_DATA;
         S_Q_DATA:     state_in = S_DONE;
         S_CLR:        if (status.sweep_last) state_in = S_DONE;
         S_RUN_CLR:    if (status.sweep_last) state_in = S_RUN_SRC;
         S_RUN_SRC:    state_in = S_LOOP;
         S_LOOP:       state_in = status.size_zero ? S_DONE : S_POP_RDL;
         S_POP_RDL:    state_in = S_POP_LAST;
         S_POP_LAST:   state_in = status.size_zero ? S_CHK_RD : S_SIFT_RL;
         S_SIFT_RL:    state_in = status.l_in ? S_SIFT_RR : S_SIFT_PLACE;
         S_SIFT_RR:    state_in = S_SIFT_STEP;
         S_SIFT_STEP:  state_in = status.sift_move ? S_SIFT_RL : S_CHK_RD;
         S_SIFT_PLACE: state_in = S_CHK_RD;
         S_CHK_RD:     state_in = S_CHK;
         S_CHK:        state_in = status.stale ? S_LOOP : S_LINK;
         S_LINK:       state_in = S_EDGE;
         S_EDGE:       state_in = status.link_zero ? S_LOOP : S_EDGE_D;
         S_EDGE_D:     state_in = S_RELAX;
         S_RELAX:      state_in = (status.relax_ok && !status.heap_full) ? S_UP_CHK : S_EDGE;
         S_UP_CHK:     state_in = status.i_zero ? S_EDGE : S_UP_STEP;
         S_UP_STEP:    state_in = status.up_stop ? S_EDGE : S_UP_CHK;
         S_DONE:       if (status.out_free) state_in = S_IDLE;
         default:      state_in = S_INIT;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != S_IDLE);
      unique case (state_ff)
         S_INIT, S_CLR: cmd = CMD_HEAD_SWEEP;
         S_IDLE:        cmd = req_valid ? CMD_ACCEPT : CMD_NONE;
         S_ADD_CHK:     cmd = CMD_ADD_RD_A;
         S_ADD_W1:      cmd = CMD_ADD_WR_A;
         S_ADD_RD_B:    cmd = CMD_ADD_RD_B;
         S_ADD_W2:      cmd = CMD_ADD_WR_B;
         S_Q_RD:        cmd = CMD_Q_RD;
         S_Q_DATA:      cmd = CMD_Q_DATA;
         S_RUN_CLR:     cmd = CMD_DIST_SWEEP;
         S_RUN_SRC:     cmd = CMD_RUN_SRC;
         S_LOOP:        cmd = CMD_POP_RD0;
         S_POP_RDL:     cmd = CMD_POP_RDL;
         S_POP_LAST:    cmd = CMD_POP_LAST;
         S_SIFT_RL:     cmd = CMD_SIFT_RDL;
         S_SIFT_RR:     cmd = CMD_SIFT_RDR;
         S_SIFT_STEP:   cmd = CMD_SIFT_STEP;
         S_SIFT_PLACE:  cmd = CMD_SIFT_PLACE;
         S_CHK_RD:      cmd = CMD_CHK_RD;
         S_CHK:         cmd = CMD_CHK;
         S_LINK:        cmd = CMD_LINK;
         S_EDGE:        cmd = CMD_EDGE_RD;
         S_EDGE_D:      cmd = CMD_EDGE_DATA;
         S_RELAX:       cmd = CMD_RELAX;
         S_UP_CHK:      cmd = CMD_UP_CHK;
         S_UP_STEP:     cmd = CMD_UP_STEP;
         S_DONE:        cmd = status.out_free ? CMD_OUT : CMD_NONE;
         default:       cmd = CMD_NONE;
      endcase
   end

endmodule

// ===== design/ssp_datapath.sv =====
// ----------------------------------------------------------------------------
// Shortest-path engine datapath
// Adjacency, distance and heap memories with the working registers.
// ----------------------------------------------------------------------------
module ssp_datapath import ssp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   input  req_type    req_data,
   input  logic       rsp_stall,
   output status_type status,
   output logic       rsp_valid,
   output rsp_type    rsp_data
);

   // memory ports
   logic                hd_we;
   logic [VTX_W-1:0]    hd_waddr, hd_raddr;
   logic [LINK_W-1:0]   hd_wdata, hd_rdata;
   logic                ed_we;
   logic [EADR_W-1:0]   ed_waddr, ed_raddr;
   edge_type            ed_wdata, ed_rdata;
   logic                ds_we;
   logic [VTX_W-1:0]    ds_waddr, ds_raddr;
   dist_type            ds_wdata, ds_rdata;
   logic                hp_we;
   logic [HADR_W-1:0]   hp_waddr, hp_raddr;
   heap_type            hp_wdata, hp_rdata;

   req_type               req_ff;
   rsp_type               res_ff, rsp_ff;
   logic                  rsp_valid_ff;
   logic [CNT_W-1:0]      cnt_ff, size_ff;
   logic [VTX_W-1:0]      sweep_ff;
   logic [DIST_BITS-1:0]  key_ff, nd_ff;
   logic [VTX_W-1:0]      here_ff, nx_ff;
   logic [LINK_W-1:0]     link_ff;
   heap_type              x_ff, best_ff;
   logic [HADR_W-1:0]     i_ff, best_idx_ff;
   logic                  best_sel_ff;

   logic [HADR_W:0]       l_idx, r_idx;
   logic                  r_in, r_take, relax_ok;
   logic [DIST_BITS-1:0]  cur_key;
   logic [DIST_BITS:0]    sum;
   logic [DIST_BITS-1:0]  nd_sat;
   logic [HADR_W-1:0]     p_idx;

   ssp_ram #(.WIDTH(LINK_W), .DEPTH(MAX_VERTICES)) u_heads (
      .clock(clock), .we(hd_we), .waddr(hd_waddr), .wdata(hd_wdata),
      .raddr(hd_raddr), .rdata(hd_rdata));

   ssp_ram #(.WIDTH($bits(edge_type)), .DEPTH(DIR_SLOTS)) u_edges (
      .clock(clock), .we(ed_we), .waddr(ed_waddr), .wdata(ed_wdata),
      .raddr(ed_raddr), .rdata(ed_rdata));

   ssp_ram #(.WIDTH($bits(dist_type)), .DEPTH(MAX_VERTICES)) u_dist (
      .clock(clock), .we(ds_we), .waddr(ds_waddr), .wdata(ds_wdata),
      .raddr(ds_raddr), .rdata(ds_rdata));

   ssp_ram #(.WIDTH($bits(heap_type)), .DEPTH(HEAP_SLOTS)) u_heap (
      .clock(clock), .we(hp_we), .waddr(hp_waddr), .wdata(hp_wdata),
      .raddr(hp_raddr), .rdata(hp_rdata));

   assign l_idx   = {i_ff, 1'b1};
   assign r_idx   = l_idx + (HADR_W+1)'(1);
   assign r_in    = r_idx < (HADR_W+1)'(size_ff);
   assign cur_key = best_sel_ff ? best_ff.key : x_ff.key;
   assign r_take  = r_in && (hp_rdata.key < cur_key);
   assign p_idx   = (i_ff - HADR_W'(1)) >> 1;
   assign sum     = (DIST_BITS+1)'(key_ff) + (DIST_BITS+1)'(ed_rdata.weight);
   // A distance that would pass the top of the field saturates there.
   assign nd_sat  = sum[DIST_BITS] ? {DIST_BITS{1'b1}} : sum[DIST_BITS-1:0];
   assign relax_ok = !ds_rdata.reached || (nd_ff < ds_rdata.len);

   always_comb begin
      status.full       = cnt_ff > CNT_W'(DIR_SLOTS - 2);
      status.sweep_last = sweep_ff == VTX_W'(MAX_VERTICES - 1);
      status.size_zero  = size_ff == '0;
      status.l_in       = l_idx < (HADR_W+1)'(size_ff);
      status.sift_move  = r_take || best_sel_ff;
      status.stale      = key_ff > ds_rdata.len;
      status.link_zero  = link_ff == '0;
      status.relax_ok   = relax_ok;
      status.heap_full  = size_ff == CNT_W'(HEAP_SLOTS);
      status.i_zero     = i_ff == '0;
      status.up_stop    = hp_rdata.key <= nd_ff;
      status.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      hd_we = 1'b0; hd_waddr = '0; hd_wdata = '0; hd_raddr = '0;
      ed_we = 1'b0; ed_waddr = '0; ed_wdata = '0; ed_raddr = '0;
      ds_we = 1'b0; ds_waddr = '0; ds_wdata = '0; ds_raddr = '0;
      hp_we = 1'b0; hp_waddr = '0; hp_wdata = '0; hp_raddr = '0;
      case (cmd)
         CMD_HEAD_SWEEP: begin
            hd_we    = 1'b1;
            hd_waddr = sweep_ff;
         end
         CMD_ADD_RD_A: hd_raddr = req_ff.vertex_a;
         CMD_ADD_WR_A, CMD_ADD_WR_B: begin
            hd_we    = 1'b1;
            hd_waddr = (cmd == CMD_ADD_WR_A) ? req_ff.vertex_a : req_ff.vertex_b;
            hd_wdata = LINK_W'(cnt_ff + CNT_W'(1));
            ed_we    = 1'b1;
            ed_waddr = cnt_ff[EADR_W-1:0];
            ed_wdata.dest   = (cmd == CMD_ADD_WR_A) ? req_ff.vertex_b : req_ff.vertex_a;
            ed_wdata.weight = req_ff.edge_weight[WEIGHT_BITS-1:0];
            ed_wdata.next   = hd_rdata;
         end
         CMD_ADD_RD_B: hd_raddr = req_ff.vertex_b;
         CMD_Q_RD:     ds_raddr = req_ff.vertex_a;
         CMD_DIST_SWEEP: begin
            ds_we    = 1'b1;
            ds_waddr = sweep_ff;
         end
         CMD_RUN_SRC: begin
            ds_we            = 1'b1;
            ds_waddr         = req_ff.vertex_a;
            ds_wdata.reached = 1'b1;
            hp_we            = 1'b1;
            hp_wdata.vtx     = req_ff.vertex_a;
         end
         CMD_POP_RDL:  hp_raddr = HADR_W'(size_ff - CNT_W'(1));
         CMD_SIFT_RDL: hp_raddr = l_idx[HADR_W-1:0];
         CMD_SIFT_RDR: hp_raddr = r_idx[HADR_W-1:0];
         CMD_SIFT_STEP: begin
            hp_we    = 1'b1;
            hp_waddr = i_ff;
            hp_wdata = r_take ? hp_rdata : (best_sel_ff ? best_ff : x_ff);
         end
         CMD_SIFT_PLACE: begin
            hp_we    = 1'b1;
            hp_waddr = i_ff;
            hp_wdata = x_ff;
         end
         CMD_CHK_RD:    ds_raddr = here_ff;
         CMD_CHK:       hd_raddr = here_ff;
         CMD_EDGE_RD:   ed_raddr = EADR_W'(link_ff - LINK_W'(1));
         CMD_EDGE_DATA: ds_raddr = ed_rdata.dest;
         CMD_RELAX: begin
            ds_we            = relax_ok;
            ds_waddr         = nx_ff;
            ds_wdata.len     = nd_ff;
            ds_wdata.reached = 1'b1;
         end
         CMD_UP_CHK: begin
            hp_we        = i_ff == '0;
            hp_wdata.key = nd_ff;
            hp_wdata.vtx = nx_ff;
            hp_raddr     = p_idx;
         end
         CMD_UP_STEP: begin
            hp_we    = 1'b1;
            hp_waddr = i_ff;
            if (hp_rdata.key <= nd_ff) begin
               hp_wdata.key = nd_ff;
               hp_wdata.vtx = nx_ff;
            end else begin
               hp_wdata = hp_rdata;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         size_ff      <= '0;
         sweep_ff     <= '0;
      end else begin
         if (cmd == CMD_OUT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (cmd)
            CMD_ACCEPT: begin
               req_ff   <= req_data;
               res_ff   <= '0;
               sweep_ff <= '0;
            end
            CMD_HEAD_SWEEP: begin
               sweep_ff <= sweep_ff + VTX_W'(1);
               cnt_ff   <= '0;
            end
            CMD_ADD_RD_A: res_ff.status <= status.full;
            CMD_ADD_WR_A, CMD_ADD_WR_B: cnt_ff <= cnt_ff + CNT_W'(1);
            CMD_Q_DATA: begin
               res_ff.distance  <= ds_rdata.reached ? ds_rdata.len : '0;
               res_ff.reachable <= ds_rdata.reached;
            end
            CMD_DIST_SWEEP: begin
               sweep_ff <= sweep_ff + VTX_W'(1);
               size_ff  <= '0;
            end
            CMD_RUN_SRC: size_ff <= CNT_W'(1);
            CMD_POP_RDL: begin
               key_ff  <= hp_rdata.key;
               here_ff <= hp_rdata.vtx;
               size_ff <= size_ff - CNT_W'(1);
            end
            CMD_POP_LAST: begin
               x_ff <= hp_rdata;
               i_ff <= '0;
            end
            CMD_SIFT_RDR: begin
               best_ff     <= hp_rdata;
               best_idx_ff <= l_idx[HADR_W-1:0];
               best_sel_ff <= hp_rdata.key < x_ff.key;
            end
            CMD_SIFT_STEP: begin
               if (r_take) begin
                  i_ff <= r_idx[HADR_W-1:0];
               end else if (best_sel_ff) begin
                  i_ff <= best_idx_ff;
               end
            end
            CMD_LINK: link_ff <= hd_rdata;
            CMD_EDGE_DATA: begin
               nx_ff   <= ed_rdata.dest;
               nd_ff   <= nd_sat;
               link_ff <= ed_rdata.next;
            end
            CMD_RELAX: begin
               if (relax_ok && !status.heap_full) begin
                  i_ff    <= HADR_W'(size_ff);
                  size_ff <= size_ff + CNT_W'(1);
               end
            end
            CMD_UP_STEP: begin
               if (hp_rdata.key > nd_ff) begin
                  i_ff <= p_idx;
               end
            end
            CMD_OUT: rsp_ff <= res_ff;
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== design/single_source_shortest_paths.sv =====
// ----------------------------------------------------------------------------
// Single-source shortest paths engine
// Each request word carries one operation: add an undirected edge, run a
// search from a source vertex, query one vertex's distance, or clear the
// graph. Every request gives exactly one response word on the rsp channel.
// Requests are taken one at a time; req_stall is high while one is in work.
// An add edge writes both directions to the edge store unless the store
// is full; a query reads the distance memory; a clear makes a write pass
// over the list-head memory; a run makes a pass over the distance memory,
// then pops heap entries, skipping stale ones, with a sift-down of the moved
// last entry, and scans each edge list, with a sift-up for each entry pushed.
// After reset the block clears the list heads before
// the first request is taken. A query before any run returns undefined data.
// A stalled response is held in an output register; the next request may
// be accepted meanwhile and its response waits until the register frees.
// ----------------------------------------------------------------------------
module single_source_shortest_paths import ssp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   ssp_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid),
      .req_func(req_data.func), .status(status), .req_stall(req_stall),
      .cmd(cmd));

   ssp_datapath u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .req_data(req_data),
      .rsp_stall(rsp_stall), .status(status), .rsp_valid(rsp_valid),
      .rsp_data(rsp_data));

endmodule
